[rtl/scc_pkg.sv]
// Package for the strongly connected components block: sizes, codes, states.
`default_nettype none
package scc_pkg;
  localparam int MAX_VERTICES = 1024;
  localparam int MAX_EDGES    = 4096;
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int EW = $clog2(MAX_EDGES);
  localparam int VCW = VW + 1;
  localparam int ECW = EW + 1;
  localparam int FW  = VW + ECW;

  localparam logic [1:0] CMD_CLEAR   = 2'd0;
  localparam logic [1:0] CMD_ADD     = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;
  localparam logic [1:0] CMD_READ    = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_OUTER, S_OUTER_RD, S_OUTER_CHK, S_PUSH,
    S_TOP, S_TOP_WAIT, S_EDGE, S_EDGE_WAIT, S_EDGE_CHK, S_VIS_WAIT, S_VIS_CHK,
    S_POP, S_P2_START, S_P2_RD, S_P2_WAIT, S_P2_VIS, S_P2_VCHK, S_MARK_RD,
    S_MARK_WAIT, S_MARK_WR, S_READ_WAIT, S_RESP
  } state_t;

  typedef struct packed {
    logic clr_init; logic clr_step; logic outer_init; logic outer_inc;
    logic cand_load; logic push_cand; logic top_rd; logic top_load;
    logic edge_rd; logic edge_take; logic edge_inc; logic vis_rd;
    logic descend; logic pop; logic p2_init; logic p2_dec; logic fin_rd;
    logic mark_rd; logic mark_wr; logic rd_buf; logic resp_load; logic set_pass2;
  } cmd_t;

  typedef struct packed {
    logic clr_done; logic outer_done; logic cand_visited; logic stack_empty;
    logic edge_done; logic edge_match; logic vis_bit; logic p2_done;
    logic cand_bad; logic rlen_zero;
  } stat_t;
endpackage
`default_nettype wire

[rtl/scc_ram.sv]
// Generic single-port-write, one-read RAM with registered read data.
`default_nettype none
module scc_ram #(parameter int WIDTH = 8, parameter int DEPTH = 16) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/scc_ctrl.sv]
// Controller state machine for the component search.
`default_nettype none
module scc_ctrl import scc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       go,
  input  wire logic [1:0] go_cmd,
  input  wire logic       out_ready,
  input  wire stat_t      st,
  output logic            busy,
  output logic            out_valid,
  output cmd_t            cm
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLR;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:       if (st.clr_done) state_nxt = S_IDLE;
      S_IDLE:
        if (go) begin
          case (go_cmd)
            CMD_COMPUTE: state_nxt = S_OUTER;
            CMD_READ:    state_nxt = S_READ_WAIT;
            default:     state_nxt = S_RESP;
          endcase
        end
      // hold until the mark sweep has finished
      S_OUTER:     if (st.clr_done) state_nxt = S_OUTER_RD;
      S_OUTER_RD:  state_nxt = S_OUTER_CHK;
      S_OUTER_CHK:
        if (st.outer_done) state_nxt = S_P2_START;
        else if (st.vis_bit) state_nxt = S_OUTER;
        else state_nxt = S_PUSH;
      S_PUSH:      state_nxt = S_TOP;
      S_TOP:       state_nxt = S_TOP_WAIT;
      S_TOP_WAIT:  state_nxt = S_EDGE;
      S_EDGE:      state_nxt = st.edge_done ? S_POP : S_EDGE_WAIT;
      S_EDGE_WAIT: state_nxt = S_EDGE_CHK;
      S_EDGE_CHK:  state_nxt = st.edge_match ? S_VIS_WAIT : S_EDGE;
      S_VIS_WAIT:  state_nxt = S_VIS_CHK;
      S_VIS_CHK:   state_nxt = st.vis_bit ? S_EDGE : S_PUSH;
      S_POP:
        if (!st.stack_empty) state_nxt = S_TOP;
        else if (st.cand_bad) state_nxt = S_MARK_RD;
        else state_nxt = S_OUTER;
      S_P2_START:  state_nxt = S_P2_RD;
      S_P2_RD:
        if (st.clr_done) state_nxt = st.p2_done ? S_RESP : S_P2_WAIT;
      S_P2_WAIT:   state_nxt = S_P2_VIS;
      S_P2_VIS:    state_nxt = st.cand_bad ? S_P2_RD : S_P2_VCHK;
      S_P2_VCHK:   state_nxt = st.vis_bit ? S_P2_RD : S_PUSH;
      S_MARK_RD:   state_nxt = st.rlen_zero ? S_P2_RD : S_MARK_WAIT;
      S_MARK_WAIT: state_nxt = S_MARK_WR;
      S_MARK_WR:   state_nxt = S_P2_RD;
      S_READ_WAIT: state_nxt = S_RESP;
      S_RESP:      if (out_ready) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cm = '0;
    busy = (state_r != S_IDLE);
    out_valid = (state_r == S_RESP);
    case (state_r)
      S_CLR:  cm.clr_step = 1'b1;
      S_IDLE:
        if (go) begin
          cm.resp_load = 1'b1;
          if (go_cmd == CMD_COMPUTE) begin
            cm.outer_init = 1'b1; cm.clr_init = 1'b1;
          end
          if (go_cmd == CMD_READ) cm.rd_buf = 1'b1;
        end
      S_OUTER:     begin cm.clr_step = 1'b1; cm.cand_load = 1'b1; end
      S_OUTER_RD:  cm.clr_step = 1'b1;
      S_OUTER_CHK: begin
        cm.clr_step = 1'b1;
        if (!st.outer_done) begin
          if (st.vis_bit) cm.outer_inc = 1'b1;
          else cm.push_cand = 1'b1;
        end
      end
      S_PUSH:      cm.descend = 1'b1;
      S_TOP:       cm.top_rd = 1'b1;
      S_TOP_WAIT:  cm.top_load = 1'b1;
      S_EDGE:      cm.edge_rd = 1'b1;
      S_EDGE_CHK:  if (st.edge_match) cm.vis_rd = 1'b1; else cm.edge_inc = 1'b1;
      S_VIS_WAIT:  cm.vis_rd = 1'b1;
      S_VIS_CHK:   if (st.vis_bit) cm.edge_inc = 1'b1; else cm.edge_take = 1'b1;
      S_POP:       begin
        cm.pop = 1'b1;
        if (st.stack_empty && !st.cand_bad) cm.outer_inc = 1'b1;
      end
      S_P2_START:  begin cm.p2_init = 1'b1; cm.set_pass2 = 1'b1; end
      S_P2_RD:
        if (st.clr_done && !st.p2_done) begin cm.fin_rd = 1'b1; cm.p2_dec = 1'b1; end
      S_P2_WAIT:   cm.cand_load = 1'b1;
      S_P2_VCHK:   if (!st.vis_bit) cm.push_cand = 1'b1;
      S_MARK_RD:   cm.mark_rd = 1'b1;
      S_MARK_WAIT: cm.mark_rd = 1'b1;
      S_MARK_WR:   cm.mark_wr = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

[rtl/scc_dp.sv]
// Datapath: edge stores, marks, stack, finish order and result buffer.
`default_nettype none
module scc_dp import scc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [10:0]      cfg_data,
  input  wire logic             go,
  input  wire logic [1:0]       go_cmd,
  input  wire logic [10:0]      src_in,
  input  wire logic [10:0]      dst_in,
  input  wire cmd_t             cm,
  output stat_t                 st,
  output logic [1:0]            status,
  output logic [10:0]           vertex,
  output logic                  last_comp,
  output logic                  last_all
);
  logic [10:0]  vcount_r;
  logic [VCW-1:0] n;
  logic [ECW-1:0] etot_r;
  logic [VCW-1:0] rlen_r, rptr_r, flen_r;
  logic [VCW-1:0] outer_r, p2i_r;
  logic [VCW-1:0] depth_r;
  logic [VW-1:0]  clr_r;
  logic           clr_busy_r;
  logic           pass2_r;
  logic [VW-1:0]  cand_r, topv_r;
  logic [ECW-1:0] eidx_r;
  logic [VW-1:0]  b_r;
  logic [VW:0]    cand_full_r;

  assign n = (vcount_r > 11'(MAX_VERTICES)) ? VCW'(MAX_VERTICES) : VCW'(vcount_r);

  // edge stores
  logic [VW-1:0] ef_q, et_q;
  logic add_ok;
  always_comb begin
    add_ok = (src_in >= 11'd1) && (VCW'(src_in) <= n) && (dst_in >= 11'd1) &&
             (VCW'(dst_in) <= n) && (etot_r < ECW'(MAX_EDGES));
  end
  logic [EW-1:0] e_raddr;
  assign e_raddr = eidx_r[EW-1:0];
  logic ew;
  assign ew = go && go_cmd == CMD_ADD && add_ok;
  logic [VW-1:0] src0, dst0;
  assign src0 = VW'(src_in - 11'd1);
  assign dst0 = VW'(dst_in - 11'd1);
  scc_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_ef (.clk, .we(ew),
    .waddr(etot_r[EW-1:0]), .wdata(src0), .raddr(e_raddr), .rdata(ef_q));
  scc_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_et (.clk, .we(ew),
    .waddr(etot_r[EW-1:0]), .wdata(dst0), .raddr(e_raddr), .rdata(et_q));

  logic [VW-1:0] ea, eb;
  assign ea = pass2_r ? et_q : ef_q;
  assign eb = pass2_r ? ef_q : et_q;

  // visited marks
  logic          v_we, v_wd, v_q;
  logic [VW-1:0] v_wa, v_ra;
  always_comb begin
    v_we = 1'b0; v_wa = clr_r; v_wd = 1'b0;
    if (clr_busy_r) v_we = 1'b1;
    else if (cm.push_cand) begin v_we = 1'b1; v_wa = cand_r; v_wd = 1'b1; end
    else if (cm.edge_take) begin v_we = 1'b1; v_wa = b_r; v_wd = 1'b1; end
    v_ra = cm.vis_rd ? eb : cand_r;
    if (cm.cand_load) v_ra = outer_r[VW-1:0];
  end
  scc_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_vis (.clk, .we(v_we),
    .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_q));

  // walk stack: vertex and next edge
  logic          s_we;
  logic [VW-1:0] s_wa;
  logic [FW-1:0] s_wd, s_q;
  logic [VW-1:0] pushv;
  assign pushv = cm.edge_take ? b_r : cand_r;
  always_comb begin
    s_we = 1'b0; s_wa = depth_r[VW-1:0]; s_wd = {pushv, ECW'(0)};
    if (cm.descend && depth_r < VCW'(MAX_VERTICES)) s_we = 1'b1;
    else if (cm.edge_take) begin
      s_we = 1'b1; s_wa = VW'(depth_r - 1'b1); s_wd = {topv_r, ECW'(eidx_r + 1'b1)};
    end
  end
  scc_ram #(.WIDTH(FW), .DEPTH(MAX_VERTICES)) u_stk (.clk, .we(s_we),
    .waddr(s_wa), .wdata(s_wd), .raddr(VW'(depth_r - 1'b1)), .rdata(s_q));

  // finish order
  logic          f_we;
  assign f_we = cm.pop && !pass2_r && flen_r < VCW'(MAX_VERTICES);
  logic [VW-1:0] f_q;
  scc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_fin (.clk, .we(f_we),
    .waddr(flen_r[VW-1:0]), .wdata(topv_r), .raddr(VW'(p2i_r - 1'b1)), .rdata(f_q));

  // result buffer: vertex plus end mark
  logic          r_we;
  logic [VW-1:0] r_wa, r_ra;
  logic [VW:0]   r_wd, r_q;
  logic          rec;
  assign rec = pass2_r && (cm.push_cand || cm.edge_take) && rlen_r < VCW'(MAX_VERTICES);
  always_comb begin
    r_we = rec; r_wa = rlen_r[VW-1:0]; r_wd = {1'b0, pushv};
    if (cm.mark_wr) begin
      r_we = 1'b1; r_wa = VW'(rlen_r - 1'b1); r_wd = {1'b1, r_q[VW-1:0]};
    end
    r_ra = cm.mark_rd ? VW'(rlen_r - 1'b1) : rptr_r[VW-1:0];
  end
  scc_ram #(.WIDTH(VW+1), .DEPTH(MAX_VERTICES)) u_res (.clk, .we(r_we),
    .waddr(r_wa), .wdata(r_wd), .raddr(r_ra), .rdata(r_q));

  logic [VCW-1:0] rlen_at_start_r;
  logic rd_ok_r, rd_last_r;
  logic rd_pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= '0; etot_r <= '0; rlen_r <= '0; rptr_r <= '0; flen_r <= '0;
      clr_r <= '0; clr_busy_r <= 1'b1; pass2_r <= 1'b0; depth_r <= '0;
      outer_r <= '0; p2i_r <= '0;
    end else begin
      if (cfg_we) vcount_r <= cfg_data;
      if (clr_busy_r) begin
        clr_r <= clr_r + 1'b1;
        if (clr_r == VW'(MAX_VERTICES - 1)) clr_busy_r <= 1'b0;
      end
      if (cm.clr_init) begin clr_busy_r <= 1'b1; clr_r <= '0; end
      if (go && go_cmd == CMD_CLEAR) begin
        etot_r <= '0; rlen_r <= '0; rptr_r <= '0;
      end
      if (ew) etot_r <= etot_r + 1'b1;
      if (cm.outer_init) begin
        outer_r <= '0; flen_r <= '0; rlen_r <= '0; rptr_r <= '0;
        pass2_r <= 1'b0; depth_r <= '0;
      end
      if (cm.outer_inc) outer_r <= outer_r + 1'b1;
      if (cm.descend && depth_r < VCW'(MAX_VERTICES)) depth_r <= depth_r + 1'b1;
      if (cm.pop) depth_r <= depth_r - 1'b1;
      if (f_we) flen_r <= flen_r + 1'b1;
      if (cm.set_pass2) begin pass2_r <= 1'b1; clr_busy_r <= 1'b1; clr_r <= '0; end
      if (cm.p2_init) p2i_r <= flen_r;
      if (cm.p2_dec) p2i_r <= p2i_r - 1'b1;
      if (rec) rlen_r <= rlen_r + 1'b1;
      if (cm.rd_buf && rptr_r < rlen_r) rptr_r <= rptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cm.cand_load) begin
      if (pass2_r) begin cand_r <= f_q; cand_full_r <= {1'b0, f_q}; end
      else begin cand_r <= outer_r[VW-1:0]; cand_full_r <= outer_r[VW:0]; end
    end
    // the taken neighbor becomes the vertex pushed next
    if (cm.edge_take) cand_r <= b_r;
    if (cm.push_cand) rlen_at_start_r <= rlen_r;
    if (cm.top_load) begin topv_r <= s_q[FW-1:ECW]; eidx_r <= s_q[ECW-1:0]; end
    if (cm.edge_inc) eidx_r <= eidx_r + 1'b1;
    if (cm.vis_rd) b_r <= eb;
    if (cm.rd_buf) begin
      rd_ok_r <= rptr_r < rlen_r;
      rd_last_r <= (rptr_r + 1'b1) == rlen_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cm.resp_load) begin
      status <= (go_cmd == CMD_ADD && !add_ok) ? ST_REJECT : ST_OK;
    end
    if (cm.resp_load || cm.p2_init) begin
      vertex <= '0; last_comp <= 1'b0; last_all <= 1'b0;
    end
    if (rd_pend_r) begin
      if (rd_ok_r) begin
        status <= ST_OK; vertex <= 11'(r_q[VW-1:0]) + 11'd1;
        last_comp <= r_q[VW]; last_all <= rd_last_r;
      end else begin
        status <= ST_EMPTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rd_pend_r <= 1'b0;
    else rd_pend_r <= cm.rd_buf;
  end

  logic [VW:0] nm;
  assign nm = n[VW:0];
  always_comb begin
    st.clr_done     = !clr_busy_r;
    st.outer_done   = outer_r >= n;
    st.cand_visited = v_q;
    st.stack_empty  = depth_r == VCW'(1);
    st.edge_done    = eidx_r >= etot_r;
    st.edge_match   = (ea == topv_r) && (VCW'(ea) < n) && (VCW'(eb) < n);
    st.vis_bit      = v_q;
    st.p2_done      = p2i_r == '0;
    st.cand_bad     = pass2_r && (cand_full_r >= nm);
    st.rlen_zero    = rlen_r == rlen_at_start_r;
    if (pass2_r && st.stack_empty) st.cand_bad = 1'b1;
  end
endmodule
`default_nettype wire

[rtl/strongly_connected_components.sv]
// Top level of the strongly connected components block.
//  channel | dir | handshake           | payload
//  in_     | in  | in_valid/in_ready   | command, edge_source, edge_target
//  out_    | out | out_valid/out_ready | status, vertex, last_in_component, last_overall
//  cfg_    | in  | cfg_we              | vertex_count
// One beat in, one beat out.
// Compute waits out a mark-clear sweep of all MAX_VERTICES marks in each pass and
// scans the edge list for each stack frame.
// After reset a sweep clears all MAX_VERTICES marks; in_ready is low meanwhile.
// The result waits in the output register until out_ready.
`default_nettype none
module strongly_connected_components import scc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [10:0] cfg_vertex_count,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [10:0] in_edge_source,
  input  wire logic [10:0] in_edge_target,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [10:0]      out_vertex,
  output logic             out_last_in_component,
  output logic             out_last_overall
);
  cmd_t  cm;
  stat_t st;
  logic  busy, go;
  assign in_ready = !busy;
  assign go = in_valid && in_ready;

  scc_ctrl u_ctrl (.clk, .rst_n, .go, .go_cmd(in_command), .out_ready, .st,
    .busy, .out_valid, .cm);

  scc_dp u_dp (.clk, .rst_n, .cfg_we, .cfg_data(cfg_vertex_count), .go,
    .go_cmd(in_command), .src_in(in_edge_source), .dst_in(in_edge_target), .cm, .st,
    .status(out_status), .vertex(out_vertex), .last_comp(out_last_in_component),
    .last_all(out_last_overall));
endmodule
`default_nettype wire

[tb/scc_checker.sv]
// Checker for the strongly connected components block: predicts each result and compares it.
`timescale 1ns / 100ps
module scc_checker import scc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [10:0] cfg_vertex_count,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [10:0] in_edge_source,
  input  wire logic [10:0] in_edge_target,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [1:0]  out_status,
  input  wire logic [10:0] out_vertex,
  input  wire logic        out_last_in_component,
  input  wire logic        out_last_overall,
  output int               fail_count,
  output int               pending
);
  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] vertex;
    logic        last_comp;
    logic        last_all;
  } scc_beat_t;

  scc_beat_t      want_q[$];
  logic [10:0]    vcount;
  logic [VW-1:0]  src_mem [MAX_EDGES];
  logic [VW-1:0]  dst_mem [MAX_EDGES];
  int             edge_cnt;
  bit             seen    [MAX_VERTICES];
  logic [VW-1:0]  fin_mem [MAX_VERTICES];
  int             fin_len;
  int             stk_v   [MAX_VERTICES];
  int             stk_e   [MAX_VERTICES];
  logic [VW-1:0]  comp_v  [MAX_VERTICES];
  bit             comp_end[MAX_VERTICES];
  int             comp_len;
  int             rd_ptr;

  function automatic int live_count();
    return (vcount > MAX_VERTICES) ? MAX_VERTICES : int'(vcount);
  endfunction

  function automatic void dfs(int start, bit rev, int n);
    int depth, e, a, b, tv;
    bit down;
    depth = 0;
    seen[start] = 1;
    if (rev && comp_len < MAX_VERTICES) begin
      comp_v[comp_len] = start; comp_end[comp_len] = 0; comp_len++;
    end
    stk_v[0] = start; stk_e[0] = 0; depth = 1;
    while (depth > 0) begin
      tv = stk_v[depth-1];
      down = 0;
      for (e = stk_e[depth-1]; e < edge_cnt; e++) begin
        a = rev ? int'(dst_mem[e]) : int'(src_mem[e]);
        b = rev ? int'(src_mem[e]) : int'(dst_mem[e]);
        if (a != tv || a >= n || b >= n || seen[b]) continue;
        stk_e[depth-1] = e + 1;
        seen[b] = 1;
        if (rev && comp_len < MAX_VERTICES) begin
          comp_v[comp_len] = b; comp_end[comp_len] = 0; comp_len++;
        end
        if (depth < MAX_VERTICES) begin
          stk_v[depth] = b; stk_e[depth] = 0; depth++;
        end
        down = 1;
        break;
      end
      if (!down) begin
        if (!rev && fin_len < MAX_VERTICES) begin
          fin_mem[fin_len] = tv; fin_len++;
        end
        depth--;
      end
    end
  endfunction

  function automatic void find_components();
    int n, i, v, mark;
    n = live_count();
    foreach (seen[k]) seen[k] = 0;
    fin_len = 0; comp_len = 0; rd_ptr = 0;
    for (i = 0; i < n; i++) if (!seen[i]) dfs(i, 0, n);
    foreach (seen[k]) seen[k] = 0;
    for (i = fin_len; i > 0; i--) begin
      v = fin_mem[i-1];
      if (v < n && !seen[v]) begin
        mark = comp_len;
        dfs(v, 1, n);
        if (comp_len > mark) comp_end[comp_len-1] = 1;
      end
    end
  endfunction

  function automatic scc_beat_t predict(logic [1:0] cmd, logic [10:0] s, logic [10:0] d);
    scc_beat_t r;
    int n;
    r = '0;
    n = live_count();
    case (cmd)
      CMD_CLEAR: begin
        edge_cnt = 0; comp_len = 0; rd_ptr = 0;
      end
      CMD_ADD: begin
        if (s < 1 || s > n || d < 1 || d > n || edge_cnt >= MAX_EDGES) r.status = ST_REJECT;
        else begin
          src_mem[edge_cnt] = VW'(s - 1);
          dst_mem[edge_cnt] = VW'(d - 1);
          edge_cnt++;
        end
      end
      CMD_COMPUTE: find_components();
      default: begin
        if (rd_ptr >= comp_len) r.status = ST_EMPTY;
        else begin
          r.vertex    = 11'(comp_v[rd_ptr]) + 11'd1;
          r.last_comp = comp_end[rd_ptr];
          r.last_all  = (rd_ptr + 1 == comp_len);
          rd_ptr++;
        end
      end
    endcase
    return r;
  endfunction

  assign pending = want_q.size();

  always @(posedge clk) begin
    scc_beat_t got, want;
    if (!rst_n) begin
      want_q.delete();
      vcount = 0; edge_cnt = 0; comp_len = 0; rd_ptr = 0; fin_len = 0;
      fail_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_status, out_vertex, out_last_in_component, out_last_overall};
        if (want_q.size() == 0) begin
          if (fail_count < 10) $display("Unexpected result beat %p at %0t", got, $realtime);
          fail_count <= fail_count + 1;
        end else begin
          want = want_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("Mismatch at %0t: expected %p, actual %p", $realtime, want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready)
        want_q.insert(want_q.size(), predict(in_command, in_edge_source, in_edge_target));
      if (cfg_we) vcount = cfg_vertex_count;
    end
  end
endmodule

[tb/tb.sv]
// Testbench top for the strongly connected components block: stimulus and verdict.
`timescale 1ns / 100ps
module tb;
  import scc_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [10:0] cfg_vertex_count = '0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  in_command = CMD_CLEAR;
  logic [10:0] in_edge_source = '0;
  logic [10:0] in_edge_target = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [1:0]  out_status;
  logic [10:0] out_vertex;
  logic        out_last_in_component;
  logic        out_last_overall;

  int fail_count, pending;
  int sent = 0;
  int cur_n = 0;
  bit quiet = 0;       // no idling on either side near the end
  bit hold_req = 0;    // asks the receiver for one long hold-off

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  strongly_connected_components dut (.*);

  scc_checker chk (.*);

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 0;
        repeat (1500) @(posedge clk);
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_ready <= 1;
        @(posedge clk);
      end
    end
  end

  // One input beat; valid stays up until the block takes it.
  task automatic send(logic [1:0] cmd, logic [10:0] s = 0, logic [10:0] d = 0);
    in_valid       <= 1;
    in_command     <= cmd;
    in_edge_source <= s;
    in_edge_target <= d;
    do @(posedge clk); while (!in_ready);
    sent++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Sender pause: wait for every outstanding result, then let the block settle.
  task automatic drain();
    in_valid <= 0;
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
  endtask

  // Register write only while the block is idle.
  task automatic set_count(logic [10:0] v);
    drain();
    cfg_we <= 1;
    cfg_vertex_count <= v;
    @(posedge clk);
    cfg_we <= 0;
    cur_n = (v > MAX_VERTICES) ? MAX_VERTICES : int'(v);
    @(posedge clk);
  endtask

  // Mostly legal endpoints, sometimes out of range or raw 11-bit noise.
  function automatic logic [10:0] pick_vertex();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 11'($urandom);
    if (r == 1) return 11'd0;
    if (r == 2) return 11'(cur_n + 1);
    if (cur_n == 0) return 11'($urandom_range(1, 3));
    return 11'($urandom_range(1, cur_n));
  endfunction

  task automatic read_all(int extra);
    for (int i = 0; i < extra; i++) send(CMD_READ);
  endtask

  initial begin
    int n, k;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: empty reads, zero vertices, rejects, a small known graph.
    send(CMD_READ);
    send(CMD_COMPUTE);
    send(CMD_READ);
    send(CMD_ADD, 1, 2);
    set_count(4);
    send(CMD_ADD, 0, 1);
    send(CMD_ADD, 5, 1);
    send(CMD_ADD, 11'h7ff, 11'h7ff);
    send(CMD_ADD, 1, 2);
    send(CMD_ADD, 2, 1);
    send(CMD_ADD, 2, 3);
    send(CMD_ADD, 3, 4);
    send(CMD_ADD, 4, 3);
    send(CMD_COMPUTE);
    send(CMD_READ);
    send(CMD_READ);
    send(CMD_ADD, 1, 4);    // late edge leaves output readable
    read_all(4);
    // Lowered count: edges touching vertex 4 drop out.
    set_count(3);
    send(CMD_COMPUTE);
    read_all(4);
    send(CMD_CLEAR);
    send(CMD_READ);

    // Oversized count behaves as the maximum; a handful of edges.
    set_count(11'h7ff);
    send(CMD_CLEAR);
    send(CMD_ADD, 1, 1024);
    send(CMD_ADD, 1024, 1);
    send(CMD_ADD, 1025, 1);
    send(CMD_ADD, 512, 1024);
    send(CMD_COMPUTE);
    read_all(6);

    // Long receiver hold-off while reads keep coming.
    hold_req = 1;
    read_all(8);
    drain();

    // Random graphs, mostly well formed.
    while (sent < 440) begin
      if (sent > 380) quiet = 1;
      case ($urandom_range(0, 9))
        0:       n = 0;
        1:       n = 1;
        2:       n = $urandom_range(13, 40);
        default: n = $urandom_range(2, 12);
      endcase
      set_count(11'(n));
      send(CMD_CLEAR);
      k = $urandom_range(0, 3 * n + 2);
      for (int i = 0; i < k; i++) begin
        if ($urandom_range(0, 24) == 0) send(2'($urandom));
        else send(CMD_ADD, pick_vertex(), pick_vertex());
      end
      if ($urandom_range(0, 5) == 0 && n > 1) set_count(11'($urandom_range(1, n - 1)));
      send(CMD_COMPUTE);
      for (int i = 0; i < cur_n + 2; i++) begin
        if ($urandom_range(0, 15) == 0) send(CMD_ADD, pick_vertex(), pick_vertex());
        else send(CMD_READ);
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("Mismatches found");
    $finish;
  end
endmodule
